// ----- rtl/core/url_pd_pkg.sv -----
// Shared types, character constants and the hex digit helper of the URL
// percent decoder. No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package url_pd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_ZERO    = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE    = 8'h39;
  localparam logic [ByteW-1:0] CH_LOW_A   = 8'h61;
  localparam logic [ByteW-1:0] CH_LOW_F   = 8'h66;
  localparam logic [ByteW-1:0] CASE_BIT   = 8'h20;
  localparam logic [NibW-1:0]  LETTER_OFS = 4'd9;

  // Sequence phase: plain text, after a percent sign, after one hex digit.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  // One raw input word.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } item_t;

  // One decoded result word.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             bad;
    logic             last;
  } result_t;

  // Hex digit check and value, either case.
  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [ByteW-1:0] c);
    hex_t             h;
    logic [ByteW-1:0] lc;
    lc = c | CASE_BIT;
    h.ok    = 1'b0;
    h.value = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.ok    = 1'b1;
      h.value = c[NibW-1:0];
    end else if (lc >= CH_LOW_A && lc <= CH_LOW_F) begin
      h.ok    = 1'b1;
      h.value = c[NibW-1:0] + LETTER_OFS;
    end
    return h;
  endfunction

endpackage

// ----- rtl/core/url_pd_in_stage.sv -----
// Input register of the URL percent decoder: holds one raw word.
// Depends on url_pd_pkg.
`timescale 1ns / 1ps

module url_pd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  url_pd_pkg::item_t  in_item,
  output logic               held_valid,
  input  logic               held_take,
  output url_pd_pkg::item_t  held_item
);

  logic              valid;
  url_pd_pkg::item_t item;

  // The register refills in the same cycle in which its word moves on.
  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/core/url_pd_core.sv -----
// Decode logic of the URL percent decoder: phase, high nibble, error flag
// and the form mode register, plus the per-word decision.
// Depends on url_pd_pkg.
`timescale 1ns / 1ps

module url_pd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                advance,
  input  url_pd_pkg::item_t   item,
  output url_pd_pkg::result_t result
);

  logic                             form_mode;
  url_pd_pkg::phase_t               phase;
  url_pd_pkg::phase_t               phase_next;
  logic [url_pd_pkg::NibW-1:0]      high_nibble;
  logic [url_pd_pkg::NibW-1:0]      high_nibble_next;
  logic                             error_seen;
  logic                             error_seen_next;
  logic                             err_now;
  url_pd_pkg::hex_t                 hex;

  assign hex = url_pd_pkg::hex_digit(item.data);

  // Next state. The error flag as it stands after this word is also what the
  // result reports; the final word then clears everything for the next string.
  always_comb begin
    phase_next       = url_pd_pkg::PH_PLAIN;
    high_nibble_next = high_nibble;
    err_now          = error_seen;
    if (!error_seen) begin
      unique case (phase)
        url_pd_pkg::PH_ONE: begin
          if (hex.ok && !item.last) begin
            high_nibble_next = hex.value;
            phase_next       = url_pd_pkg::PH_TWO;
          end else begin
            err_now = 1'b1;
          end
        end
        url_pd_pkg::PH_TWO: begin
          if (!hex.ok) begin
            err_now = 1'b1;
          end
        end
        default: begin
          if (item.data == url_pd_pkg::CH_PERCENT) begin
            if (item.last) begin
              err_now = 1'b1;
            end else begin
              phase_next = url_pd_pkg::PH_ONE;
            end
          end
        end
      endcase
    end
    error_seen_next = err_now;
    if (item.last) begin
      phase_next       = url_pd_pkg::PH_PLAIN;
      high_nibble_next = '0;
      error_seen_next  = 1'b0;
    end
  end

  // Result word.
  always_comb begin
    result.data  = '0;
    result.valid = 1'b0;
    result.bad   = err_now;
    result.last  = item.last;
    if (!error_seen) begin
      unique case (phase)
        url_pd_pkg::PH_ONE: begin
          result.valid = 1'b0;
        end
        url_pd_pkg::PH_TWO: begin
          if (hex.ok) begin
            result.data  = {high_nibble, hex.value};
            result.valid = 1'b1;
          end
        end
        default: begin
          if (item.data == url_pd_pkg::CH_PERCENT) begin
            result.valid = 1'b0;
          end else if (item.data == url_pd_pkg::CH_PLUS && form_mode) begin
            result.data  = url_pd_pkg::CH_SPACE;
            result.valid = 1'b1;
          end else begin
            result.data  = item.data;
            result.valid = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      form_mode   <= 1'b0;
      phase       <= url_pd_pkg::PH_PLAIN;
      high_nibble <= '0;
      error_seen  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        form_mode <= cfg_wr_data;
      end
      if (advance) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        error_seen  <= error_seen_next;
      end
    end
  end

endmodule

// ----- rtl/core/url_pd_out_stage.sv -----
// Result register of the URL percent decoder, facing the output stream.
// Depends on url_pd_pkg.
`timescale 1ns / 1ps

module url_pd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  url_pd_pkg::result_t up_result,
  output logic                out_valid,
  input  logic                out_ready,
  output url_pd_pkg::result_t out_result
);

  logic                valid;
  url_pd_pkg::result_t res;

  assign up_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res <= up_result;
    end
  end

endmodule

// ----- rtl/core/url_percent_decode.sv -----
// Top level of the URL percent decoder: input register, decode logic with
// the sequence state, and result register. Depends on url_pd_pkg,
// url_pd_in_stage, url_pd_core and url_pd_out_stage.
//
//   Channel   Direction  Word contents (lowest bit first)
//   s_axis    in         tdata: in_byte[7:0]; tlast: in_last
//   m_axis    out        tdata: out_byte[7:0]; tuser: out_valid, bad_sequence;
//                        tlast: out_last
//   cfg       in         cfg_wr_data: form_mode, taken when cfg_wr_en is high
//
// Every input word yields exactly one output word. A word is held in the input
// register and is decoded on its way into the result register, and a new word
// is taken every cycle while m_axis_tready stays high. The throughput is then
// one word per cycle, set by the single decode step between the two registers;
// the sequence state updates as a word enters the result register. When
// m_axis_tready is low the result register holds, the input register fills
// behind it and s_axis_tready then falls. The synchronous reset clears the
// valid flags, the phase, the high nibble, the error flag and form_mode; no
// further setup is needed after reset.
`timescale 1ns / 1ps

module url_percent_decode (
  input  logic       clk,
  input  logic       rst,
  // Configuration: form_mode.
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  // Output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] out_valid, [1] bad_sequence
  output logic       m_axis_tlast    // out_last
);

  url_pd_pkg::item_t   in_item;
  url_pd_pkg::item_t   held_item;
  logic                held_valid;
  logic                mid_ready;
  logic                advance;
  url_pd_pkg::result_t dec_result;
  url_pd_pkg::result_t out_result;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // A word moves from the input register into the result register only when
  // the result register can take it; that is also when the state advances.
  assign advance = held_valid && mid_ready;

  url_pd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (mid_ready),
    .held_item  (held_item)
  );

  url_pd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (held_item),
    .result      (dec_result)
  );

  url_pd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (held_valid),
    .up_ready   (mid_ready),
    .up_result  (dec_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata    = out_result.data;
  assign m_axis_tuser[0] = out_result.valid;
  assign m_axis_tuser[1] = out_result.bad;
  assign m_axis_tlast    = out_result.last;

endmodule

// ----- sim/url_percent_decode_tb.sv -----
// Self-checking testbench for the URL percent decoder: random stream traffic
// checked word by word against a predictor of the decode rules.
// Depends on url_pd_pkg and url_percent_decode.
`timescale 1ns / 1ps

module url_percent_decode_tb;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam int LongHold   = 200;   // receiver hold-off that fills the block
  localparam int StallLimit = 2000;  // cycles without any handshake
  localparam int PhaseWords = 350;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0; // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic [1:0] m_axis_tuser;        // [0] out_valid, [1] bad_sequence
  logic       m_axis_tlast;        // out_last

  url_percent_decode u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Raw words waiting to be sent, and decoded words still to come out.
  url_pd_pkg::item_t   raw_q[$];
  url_pd_pkg::result_t decoded_q[$];
  int      words_queued = 0;
  int      words_taken  = 0;
  int      mismatches   = 0;
  logic    in_taken     = 1'b0;
  bit      quiet        = 1'b0;  // no idling on either side while set
  int      holds_asked  = 0;
  int      holds_served = 0;
  int      hold_left    = 0;
  int      recv_gap     = 0;
  int      send_gap     = 0;
  int      quiet_cycles = 0;

  // Predictor state, mirroring the decoder's sequence tracking.
  logic               dec_form  = 1'b0;
  url_pd_pkg::phase_t dec_phase = url_pd_pkg::PH_PLAIN;
  logic [3:0]         dec_high  = '0;
  logic               dec_bad   = 1'b0;

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] t;
    v = '0;
    if (c >= url_pd_pkg::CH_ZERO && c <= url_pd_pkg::CH_NINE) begin
      t = c - url_pd_pkg::CH_ZERO;
      v = t[3:0];
      return 1'b1;
    end
    if ((c >= url_pd_pkg::CH_LOW_A && c <= url_pd_pkg::CH_LOW_F) ||
        (c >= CH_UP_A && c <= CH_UP_F)) begin
      t = (c | url_pd_pkg::CASE_BIT) - url_pd_pkg::CH_LOW_A + 8'd10;
      v = t[3:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result word for one accepted raw word and moves the state on.
  function automatic url_pd_pkg::result_t decode_word(input url_pd_pkg::item_t w);
    url_pd_pkg::result_t r;
    logic [3:0]          nib;
    logic                is_hex;
    r = '0;
    is_hex = hex_nibble(w.data, nib);
    if (!dec_bad) begin
      case (dec_phase)
        url_pd_pkg::PH_ONE: begin
          // A string may not end on the first digit.
          if (is_hex && !w.last) begin
            dec_high  = nib;
            dec_phase = url_pd_pkg::PH_TWO;
          end else begin
            dec_bad   = 1'b1;
            dec_phase = url_pd_pkg::PH_PLAIN;
          end
        end
        url_pd_pkg::PH_TWO: begin
          if (is_hex) begin
            r.data  = {dec_high, nib};
            r.valid = 1'b1;
          end else begin
            dec_bad = 1'b1;
          end
          dec_phase = url_pd_pkg::PH_PLAIN;
        end
        default: begin
          dec_phase = url_pd_pkg::PH_PLAIN;
          if (w.data == url_pd_pkg::CH_PERCENT) begin
            if (w.last) dec_bad = 1'b1;
            else dec_phase = url_pd_pkg::PH_ONE;
          end else if (w.data == url_pd_pkg::CH_PLUS && dec_form) begin
            r.data  = url_pd_pkg::CH_SPACE;
            r.valid = 1'b1;
          end else begin
            r.data  = w.data;
            r.valid = 1'b1;
          end
        end
      endcase
    end
    r.bad  = dec_bad;
    r.last = w.last;
    if (w.last) begin
      dec_phase = url_pd_pkg::PH_PLAIN;
      dec_high  = '0;
      dec_bad   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sender: a new word is put up only once the previous one has gone.
  always @(negedge clk) begin
    url_pd_pkg::item_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (raw_q.size() > 0) begin
        w = raw_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.data;
        s_axis_tlast  <= w.last;
        send_gap      <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served  <= holds_served + 1;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap      <= pick_gap();
    end
  end

  // Monitor: predicts on every accepted raw word and checks every result word.
  always @(posedge clk) begin
    url_pd_pkg::result_t got;
    url_pd_pkg::result_t want;
    url_pd_pkg::item_t   w;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_wr_en) dec_form = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.data  = m_axis_tdata;
        got.valid = m_axis_tuser[0];
        got.bad   = m_axis_tuser[1];
        got.last  = m_axis_tlast;
        if (decoded_q.size() == 0) begin
          report_mismatch("word with nothing expected", 32'(got.data), 0);
        end else begin
          want = decoded_q.pop_front();
          if (got.data !== want.data)
            report_mismatch("out_byte", 32'(got.data), 32'(want.data));
          if (got.valid !== want.valid)
            report_mismatch("out_valid", 32'(got.valid), 32'(want.valid));
          if (got.bad !== want.bad)
            report_mismatch("bad_sequence", 32'(got.bad), 32'(want.bad));
          if (got.last !== want.last)
            report_mismatch("out_last", 32'(got.last), 32'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w.data = s_axis_tdata;
        w.last = s_axis_tlast;
        decoded_q.push_back(decode_word(w));
        words_taken++;
      end
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic last);
    url_pd_pkg::item_t w;
    w.data = b;
    w.last = last;
    raw_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_hex();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return url_pd_pkg::CH_ZERO + v;
    return ($urandom_range(0, 1) ? CH_UP_A : url_pd_pkg::CH_LOW_A) + (v - 8'd10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [3:0] v;
    do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, v));
    return b;
  endfunction

  // Mostly well-formed strings; some with one broken or cut-off sequence,
  // some pure noise rich in percent signs and hex digits.
  task automatic queue_random_string();
    logic [7:0]  text[$];
    logic [7:0]  b;
    int unsigned style;
    int unsigned tokens;
    int unsigned bad_at;
    int unsigned pick;
    style  = $urandom_range(0, 9);
    tokens = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
    bad_at = $urandom_range(0, tokens - 1);
    for (int i = 0; i < tokens; i++) begin
      if (style == 9) begin
        pick = $urandom_range(0, 4);
        if (pick == 0) text.push_back(url_pd_pkg::CH_PERCENT);
        else if (pick == 1) text.push_back(rand_hex());
        else text.push_back(8'($urandom_range(0, 255)));
      end else if (style >= 7 && i == bad_at) begin
        // Placed last, the two shorter forms leave the string open.
        text.push_back(url_pd_pkg::CH_PERCENT);
        pick = $urandom_range(0, 3);
        if (pick == 0) text.push_back(non_hex_byte());
        if (pick == 1 || pick == 3) text.push_back(rand_hex());
        if (pick == 1) text.push_back(non_hex_byte());
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          do b = 8'($urandom_range(0, 255)); while (b == url_pd_pkg::CH_PERCENT);
          text.push_back(b);
        end else if (pick < 6) begin
          text.push_back(url_pd_pkg::CH_PLUS);
        end else begin
          text.push_back(url_pd_pkg::CH_PERCENT);
          text.push_back(rand_hex());
          text.push_back(rand_hex());
        end
      end
    end
    for (int k = 0; k < text.size(); k++) push_word(text[k], k == text.size() - 1);
  endtask

  task automatic queue_random(input int n);
    int start;
    start = words_queued;
    while (words_queued - start < n) queue_random_string();
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (words_taken != words_queued || decoded_q.size() != 0);
  endtask

  // The register is only written once every word has come out.
  task automatic write_form(input logic v);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed strings with form_mode at its reset value.
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b1);
    queue_text("%41");
    queue_text("%fF");
    queue_text("%00+");
    queue_text("%G%41");  // bad digit, then a good sequence that is ignored
    queue_text("%");      // percent sign as the last byte
    queue_text("%4");     // string ends after the first digit
    queue_text("%az");    // bad second digit

    write_form(1'b1);
    queue_text("+a+");
    queue_random(PhaseWords);

    // A phase with no idling at all.
    write_form(1'b0);
    quiet = 1'b1;
    queue_random(PhaseWords);
    wait_idle();
    quiet = 1'b0;

    // The receiver holds off long enough for the input to back up.
    write_form(1'b1);
    holds_asked++;
    queue_random(PhaseWords);

    write_form(1'b0);
    queue_random(PhaseWords);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
